// File: design/mmbd_pkg.sv
// Shared types, register indexes and the box average for the mip chain generator.
// No dependencies.
package mmbd_pkg;

    localparam int GDW = 15;   // level size, covers the largest supported dimension
    localparam int GOW = 16;   // line store offset of a level
    localparam int GPW = 14;   // pixel position within a level

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    typedef logic [31:0] t_pix;

    typedef struct packed {
        logic           live;
        logic [GDW-1:0] w;
        logic [GDW-1:0] h;
        logic [GOW-1:0] off;
    } t_geo;

    typedef struct packed {
        logic [GPW-1:0] x;
        logic [GPW-1:0] y;
    } t_pos;

    function automatic t_pix box_avg(t_pix a, t_pix b, t_pix c, t_pix d);
        t_pix       r;
        logic [9:0] s;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            s = 10'(a[8*i +: 8]) + 10'(b[8*i +: 8]) + 10'(c[8*i +: 8]) + 10'(d[8*i +: 8]);
            r[8*i +: 8] = s[9:2];
        end
        return r;
    endfunction

endpackage

// File: design/mmbd_if.sv
// Handshake channels of the mip chain generator: pixels in, results out, register writes.
// No dependencies.
interface mmbd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_ch0;
    logic [7:0] pixel_ch1;
    logic [7:0] pixel_ch2;
    logic [7:0] pixel_ch3;
    modport source (output valid, pixel_ch0, pixel_ch1, pixel_ch2, pixel_ch3, input ready);
    modport sink   (input valid, pixel_ch0, pixel_ch1, pixel_ch2, pixel_ch3, output ready);
endinterface

interface mmbd_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  mip_level;
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [7:0]  out_ch0;
    logic [7:0]  out_ch1;
    logic [7:0]  out_ch2;
    logic [7:0]  out_ch3;
    logic        last_of_run;
    modport source (output valid, mip_level, out_x, out_y, out_ch0, out_ch1, out_ch2,
                    out_ch3, last_of_run, input ready);
    modport sink   (input valid, mip_level, out_x, out_y, out_ch0, out_ch1, out_ch2,
                    out_ch3, last_of_run, output ready);
endinterface

interface mmbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [12:0] wr_data;
    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: design/mmbd_store.sv
// Line store of top parent rows for all levels: one write port, two registered read ports.
// Depends on mmbd_pkg.
module mmbd_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  mmbd_pkg::t_pix i_wdata,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output mmbd_pkg::t_pix o_rdata0,
    output mmbd_pkg::t_pix o_rdata1
);
    import mmbd_pkg::*;

    t_pix mem [DEPTH];
    t_pix r_rd0, r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rd0 <= mem[i_raddr0];
        r_rd1 <= mem[i_raddr1];
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;
endmodule

// File: design/mmbd_cell.sv
// One level of the mip chain: its geometry (handed on to the next cell every cycle),
// its position counters and its held left pixel. Depends on mmbd_pkg.
module mmbd_cell #(
    parameter int MAX_DIM = 4096,
    parameter bit IS_LAST = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_restart,
    input  mmbd_pkg::t_geo i_geo,
    output mmbd_pkg::t_geo o_geo,
    output mmbd_pkg::t_geo o_child,
    input  logic           i_step,
    input  logic           i_hold,
    input  mmbd_pkg::t_pix i_cur,
    output mmbd_pkg::t_pos o_pos,
    output mmbd_pkg::t_pix o_held
);
    import mmbd_pkg::*;

    localparam int CW = $clog2(MAX_DIM);

    t_geo          r_geo;
    logic [CW-1:0] r_x, r_y, n_x, n_y;
    t_pix          r_held;
    logic [GDW:0]  x_inc, y_inc;

    always_ff @(posedge i_clk) begin
        r_geo <= i_geo;
        if (i_hold) begin
            r_held <= i_cur;
        end
    end

    always_comb begin
        x_inc = (GDW+1)'(r_x) + 1'b1;
        y_inc = (GDW+1)'(r_y) + 1'b1;
        n_x   = r_x;
        n_y   = r_y;
        if (x_inc >= {1'b0, r_geo.w}) begin
            n_x = '0;
            n_y = (y_inc >= {1'b0, r_geo.h}) ? '0 : CW'(y_inc);
        end else begin
            n_x = CW'(x_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_step) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    // child level: half size, at least one; chain ends after the 1x1 level or the last cell
    always_comb begin
        o_child.w    = (r_geo.w > GDW'(1)) ? (r_geo.w >> 1) : GDW'(1);
        o_child.h    = (r_geo.h > GDW'(1)) ? (r_geo.h >> 1) : GDW'(1);
        o_child.off  = r_geo.off + GOW'(r_geo.w);
        o_child.live = r_geo.live && !(r_geo.w == GDW'(1) && r_geo.h == GDW'(1)) && !IS_LAST;
    end

    assign o_geo   = r_geo;
    assign o_pos.x = GPW'(r_x);
    assign o_pos.y = GPW'(r_y);
    assign o_held  = r_held;
endmodule

// File: design/mipmap_box_downsampler.sv
// Streaming 2x2 box-filter mip chain generator over a row of per-level cells.
// Each pixel is accepted in the idle state; at each level it reaches it then passes an emit
// state (emit and read the line store) and, if it goes on to the next level, an average
// state. A full output register stalls the emit step.
// Reset and every write to the width, height or channels register clear all positions; the
// level geometry then ripples through the cells, and no pixel is taken until the settle counter has run down.
module mipmap_box_downsampler #(
    parameter int MAX_DIM      = 4096,
    parameter int MAX_LEVELS   = 13,
    parameter int MAX_CHANNELS = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mmbd_pix_if.sink   i_pix,
    mmbd_res_if.source o_res,
    mmbd_cfg_if.sink   i_cfg
);
    import mmbd_pkg::*;

    localparam int LW     = $clog2(MAX_LEVELS);
    localparam int DEPTH  = 2 * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int SETTLE = MAX_LEVELS + 1;
    localparam int SW     = $clog2(SETTLE + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_AVG  = 2'd2;

    logic [12:0] r_width, r_height;
    logic [2:0]  r_chans;
    logic [SW-1:0] r_settle;
    logic        restart;

    logic [1:0]    r_state;
    logic [LW-1:0] r_lvl;
    t_pix          r_cur;
    logic          r_dx, r_dy;

    t_geo geo   [MAX_LEVELS];
    t_geo child [MAX_LEVELS];
    t_geo geo0;
    t_pos pos   [MAX_LEVELS];
    t_pix held  [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] step, hold;

    // register writes
    assign i_cfg.ready = 1'b1;
    assign restart     = i_cfg.valid && (i_cfg.reg_index == REG_WIDTH ||
                         i_cfg.reg_index == REG_HEIGHT || i_cfg.reg_index == REG_CHANNELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd4096;
            r_height <= 13'd4096;
            r_chans  <= 3'd4;
            r_settle <= SW'(SETTLE);
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    REG_WIDTH:    r_width  <= i_cfg.wr_data;
                    REG_HEIGHT:   r_height <= i_cfg.wr_data;
                    REG_CHANNELS: r_chans  <= i_cfg.wr_data[2:0];
                    default: ;
                endcase
            end
            if (restart) begin
                r_settle <= SW'(SETTLE);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 1'b1;
            end
        end
    end

    function automatic logic [GDW-1:0] clamp_dim(logic [12:0] v);
        if (v == '0) begin
            return GDW'(1);
        end else if (32'(v) > MAX_DIM) begin
            return GDW'(MAX_DIM);
        end else begin
            return GDW'(v);
        end
    endfunction

    always_comb begin
        geo0.live = 1'b1;
        geo0.w    = clamp_dim(r_width);
        geo0.h    = clamp_dim(r_height);
        geo0.off  = '0;
    end

    // channel mask of the incoming pixel
    logic [2:0] chans_c;
    t_pix       in_pix;
    always_comb begin
        if (r_chans == '0) begin
            chans_c = 3'd1;
        end else if (32'(r_chans) > MAX_CHANNELS) begin
            chans_c = 3'(MAX_CHANNELS);
        end else begin
            chans_c = r_chans;
        end
        in_pix = {i_pix.pixel_ch3, i_pix.pixel_ch2, i_pix.pixel_ch1, i_pix.pixel_ch0};
        for (int j = 0; j < 4; j++) begin
            if (3'(j) >= chans_c) begin
                in_pix[8*j +: 8] = 8'd0;
            end
        end
    end

    // cell row
    for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
        mmbd_cell #(
            .MAX_DIM (MAX_DIM),
            .IS_LAST (k == MAX_LEVELS - 1)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_restart (restart),
            .i_geo     ((k == 0) ? geo0 : child[(k == 0) ? 0 : k - 1]),
            .o_geo     (geo[k]),
            .o_child   (child[k]),
            .i_step    (step[k]),
            .i_hold    (hold[k]),
            .i_cur     (r_cur),
            .o_pos     (pos[k]),
            .o_held    (held[k])
        );
    end

    // current level decisions
    t_geo           g, c;
    t_pos           p;
    logic           dx, dy, brk_store, brk_hold, brk_out, cont, out_free, emit;
    logic [GPW-1:0] cx, cy;
    logic [AW-1:0]  i0, waddr;
    t_pix           rd0, rd1, bl, tl, tr;

    always_comb begin
        g  = geo[r_lvl];
        c  = child[r_lvl];
        p  = pos[r_lvl];
        dx = g.w > GDW'(1);
        dy = g.h > GDW'(1);
        cx = dx ? (p.x >> 1) : p.x;
        cy = dy ? (p.y >> 1) : p.y;
        brk_store = dy && !p.y[0];
        brk_hold  = !brk_store && dx && !p.x[0];
        brk_out   = (GDW'(cx) >= c.w) || (GDW'(cy) >= c.h);
        cont      = c.live && !brk_store && !brk_hold && !brk_out;
        out_free  = !o_res.valid || o_res.ready;
        emit      = (r_state == ST_EMIT) && out_free;
        i0        = AW'(g.off) + AW'({cx, 1'b0});
        waddr     = AW'(g.off) + AW'(p.x);
        step      = '0;
        hold      = '0;
        step[r_lvl] = emit;
        hold[r_lvl] = emit && c.live && brk_hold;
    end

    mmbd_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (emit && c.live && brk_store),
        .i_waddr  (waddr),
        .i_wdata  (r_cur),
        .i_raddr0 (i0),
        .i_raddr1 (i0 + AW'(dx)),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    always_comb begin
        bl = r_dx ? held[r_lvl] : r_cur;
        tl = r_dy ? rd0 : bl;
        tr = r_dy ? rd1 : r_cur;
    end

    assign i_pix.ready = (r_state == ST_IDLE) && (r_settle == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lvl   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_pix.valid && i_pix.ready) begin
                        r_state <= ST_EMIT;
                        r_lvl   <= '0;
                    end
                end
                ST_EMIT: begin
                    if (emit) begin
                        r_state <= cont ? ST_AVG : ST_IDLE;
                    end
                end
                ST_AVG: begin
                    r_state <= ST_EMIT;
                    r_lvl   <= r_lvl + 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_cur <= in_pix;
        end else if (r_state == ST_AVG) begin
            r_cur <= box_avg(tl, tr, bl, r_cur);
        end
        if (emit) begin
            r_dx <= dx;
            r_dy <= dy;
        end
    end

    // output beat register
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_res.mip_level   <= 4'(r_lvl);
            o_res.out_x       <= p.x[11:0];
            o_res.out_y       <= p.y[11:0];
            o_res.out_ch0     <= r_cur[7:0];
            o_res.out_ch1     <= r_cur[15:8];
            o_res.out_ch2     <= r_cur[23:16];
            o_res.out_ch3     <= r_cur[31:24];
            o_res.last_of_run <= !cont;
        end
    end

    assign o_res.valid = r_ov;
endmodule
